FILE: sv/imhq_pkg.sv
// Package for the indexed min-heap queue: payload types, operation and status codes.
// Used by indexed_min_heap_queue_core; depends on nothing.
`default_nettype none
package imhq_pkg;
    localparam int MAX_VERTICES_DEF = 128;
    localparam int VTX_W = 7;
    localparam int KEY_W = 31;
    localparam int CNT_W = 8;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_DECREASE = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_QUEUED    = 3'd3;
    localparam logic [2:0] ST_ABSENT    = 3'd4;
    localparam logic [2:0] ST_NOT_LOWER = 3'd5;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VTX_W-1:0] vertex;
        logic [KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic [VTX_W-1:0] out_vertex;
        logic [KEY_W-1:0] out_key;
        logic [2:0]       status;
        logic [CNT_W-1:0] entry_count;
    } out_word_t;
endpackage
`default_nettype wire

FILE: sv/indexed_min_heap_queue_core.sv
// Indexed binary min-heap queue with decrease-key, built around one heap memory.
// Depends on imhq_pkg.
//
// Usage: s_ carries an operation word (insert, extract minimum, decrease key,
// clear); m_ returns exactly one result word per operation with the removed
// entry, a status code and the entry count afterwards.
// Errors and clear go straight to the result. Insert moves the new entry up one
// level at a time. Decrease key reads the vertex's slot and compares the keys,
// then moves the entry up the same way, or reports key not lower. Extract reads
// the root and the last entry, then lets the last entry sink one level at a time;
// removing the last entry skips the sinking. The heap memory is single-ported
// with a registered read. s_ready is high only while the block is idle and its
// result register is empty or being taken, so each word finishes before the next.
// Reset: the heap becomes empty and every vertex is marked absent through
// per-vertex valid bits; heap slots themselves are not cleared.
// Stall: a result waits in the output register while m_ready is low; the next
// word is accepted in the cycle the result is taken.
`default_nettype none
module indexed_min_heap_queue_core #(
    parameter int MAX_VERTICES = imhq_pkg::MAX_VERTICES_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  imhq_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output imhq_pkg::out_word_t  m_data
);
    localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ZW = $clog2(MAX_VERTICES + 1);
    localparam int IW = SW + 2;
    localparam int CW = imhq_pkg::CNT_W;
    localparam int VW = imhq_pkg::VTX_W;
    localparam int KW = imhq_pkg::KEY_W;
    localparam int EW = VW + KW;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_EX_ROOT, S_EX_LAST, S_DEC_POS, S_DEC_CMP,
        S_UP_RD, S_UP_CMP, S_DN_L, S_DN_R, S_DN_CMP, S_PLACE, S_DONE
    } state_t;

    // Heap memory: vertex and key together, one port.
    logic [EW-1:0] heap_mem [MAX_VERTICES];
    logic [EW-1:0] rd_data_reg;
    logic [SW-1:0] pos_mem [MAX_VERTICES];
    logic [SW-1:0] pos_rd_reg;
    logic [MAX_VERTICES-1:0] pos_valid_reg;

    state_t        state_reg;
    logic [1:0]    kind_reg;
    logic [VW-1:0] vtx_reg;
    logic [KW-1:0] key_reg;
    logic [SW-1:0] slot_reg;
    logic [ZW-1:0] size_reg;
    logic [EW-1:0] left_reg;
    logic          out_valid_reg;
    imhq_pkg::out_word_t out_reg;

    // Memory control decided combinationally from state.
    logic          mem_we;
    logic [SW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;
    logic          pos_we;
    logic [SW-1:0] pos_waddr;
    logic [SW-1:0] pos_wdata;

    logic [SW-1:0] parent_slot;
    logic [SW-1:0] vtx_idx;
    logic [IW-1:0] left_idx, right_idx;
    logic          vtx_in_range;
    logic          has_left, has_right;
    logic [VW-1:0] rd_vtx, left_vtx;
    logic [KW-1:0] rd_key, left_key, best_key;
    logic          left_wins, right_wins;

    assign parent_slot  = (slot_reg - SW'(1)) >> 1;
    assign vtx_idx      = SW'(vtx_reg);
    assign left_idx     = {1'b0, slot_reg, 1'b1};
    assign right_idx    = {1'b0, slot_reg, 1'b0} + IW'(2);
    assign vtx_in_range = (32'(vtx_reg) < MAX_VERTICES);
    assign has_left     = (left_idx < IW'(size_reg));
    assign has_right    = (right_idx < IW'(size_reg));
    assign rd_vtx       = rd_data_reg[EW-1:KW];
    assign rd_key       = rd_data_reg[KW-1:0];
    assign left_vtx     = left_reg[EW-1:KW];
    assign left_key     = left_reg[KW-1:0];
    // The sinking entry keeps its place on ties; the left child wins a tie
    // between the two children.
    assign left_wins    = (left_key < key_reg);
    assign best_key     = left_wins ? left_key : key_reg;
    assign right_wins   = has_right && (rd_key < best_key);

    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = slot_reg;
        mem_wdata = {vtx_reg, key_reg};
        pos_we    = 1'b0;
        pos_waddr = vtx_idx;
        pos_wdata = slot_reg;
        case (state_reg)
            S_CHECK:   mem_addr = '0;
            S_EX_ROOT: mem_addr = SW'(size_reg - ZW'(1));
            S_DEC_POS: mem_addr = pos_rd_reg;
            S_UP_RD:   mem_addr = parent_slot;
            S_UP_CMP: begin
                if (rd_key > key_reg) begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    pos_we    = 1'b1;
                    pos_waddr = SW'(rd_vtx);
                end
            end
            S_DN_L:    mem_addr = SW'(left_idx);
            S_DN_R:    mem_addr = SW'(right_idx);
            S_DN_CMP: begin
                if (right_wins) begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    pos_we    = 1'b1;
                    pos_waddr = SW'(rd_vtx);
                end else if (left_wins) begin
                    mem_we    = 1'b1;
                    mem_wdata = left_reg;
                    pos_we    = 1'b1;
                    pos_waddr = SW'(left_vtx);
                end
            end
            S_PLACE: begin
                mem_we = 1'b1;
                pos_we = 1'b1;
            end
            default: mem_addr = slot_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= heap_mem[mem_addr];
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[vtx_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            pos_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        kind_reg  <= s_data.kind;
                        vtx_reg   <= s_data.vertex;
                        key_reg   <= s_data.key;
                        out_reg   <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    case (kind_reg)
                        imhq_pkg::OP_INSERT: begin
                            if (!vtx_in_range) begin
                                out_reg.status <= imhq_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end else if (pos_valid_reg[vtx_idx]) begin
                                out_reg.status <= imhq_pkg::ST_QUEUED;
                                state_reg <= S_DONE;
                            end else if (32'(size_reg) >= MAX_VERTICES) begin
                                out_reg.status <= imhq_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end else begin
                                pos_valid_reg[vtx_idx] <= 1'b1;
                                slot_reg  <= SW'(size_reg);
                                size_reg  <= size_reg + ZW'(1);
                                state_reg <= S_UP_RD;
                            end
                        end
                        imhq_pkg::OP_EXTRACT: begin
                            if (size_reg == '0) begin
                                out_reg.status <= imhq_pkg::ST_EMPTY;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_EX_ROOT;
                            end
                        end
                        imhq_pkg::OP_DECREASE: begin
                            if (!vtx_in_range || !pos_valid_reg[vtx_idx]) begin
                                out_reg.status <= imhq_pkg::ST_ABSENT;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_DEC_POS;
                            end
                        end
                        default: begin
                            pos_valid_reg <= '0;
                            size_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_EX_ROOT: begin
                    out_reg.out_vertex <= rd_vtx;
                    out_reg.out_key    <= rd_key;
                    pos_valid_reg[SW'(rd_vtx)] <= 1'b0;
                    size_reg  <= size_reg - ZW'(1);
                    state_reg <= S_EX_LAST;
                end
                S_EX_LAST: begin
                    // The last entry becomes the one that sinks from the root.
                    if (size_reg == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        vtx_reg   <= rd_vtx;
                        key_reg   <= rd_key;
                        slot_reg  <= '0;
                        state_reg <= S_DN_L;
                    end
                end
                S_DEC_POS: begin
                    slot_reg <= pos_rd_reg;
                    if (IW'(pos_rd_reg) >= IW'(size_reg)) begin
                        out_reg.status <= imhq_pkg::ST_ABSENT;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DEC_CMP;
                    end
                end
                S_DEC_CMP: begin
                    if (!(key_reg < rd_key)) begin
                        out_reg.status <= imhq_pkg::ST_NOT_LOWER;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_UP_RD;
                    end
                end
                S_UP_RD: begin
                    if (slot_reg == '0) begin
                        state_reg <= S_PLACE;
                    end else begin
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (rd_key > key_reg) begin
                        slot_reg  <= parent_slot;
                        state_reg <= S_UP_RD;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_DN_L: begin
                    if (has_left) begin
                        state_reg <= S_DN_R;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_DN_R: begin
                    left_reg  <= rd_data_reg;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (right_wins) begin
                        slot_reg  <= SW'(right_idx);
                        state_reg <= S_DN_L;
                    end else if (left_wins) begin
                        slot_reg  <= SW'(left_idx);
                        state_reg <= S_DN_L;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE, S_DONE: begin
                    out_reg.entry_count <= CW'(size_reg);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
